[design/sortb_pkg.sv]
// shared types and constants for the ascending sort block
package sortb_pkg;

	localparam int VALUE_W     = 32;
	localparam int MAX_LEN_DEF = 64;

	typedef logic [VALUE_W-1:0] value_t;

	// what one cell shows to its neighbors
	typedef struct packed {
		value_t val;
		logic   occ;
		logic   gt;
	} cell_link_t;

	// broadcast control from the top level to every cell
	typedef struct packed {
		logic   ins;
		logic   pop;
		value_t x;
	} cell_ctrl_t;

endpackage

[design/sortb_cell.sv]
// one cell of the insertion chain: holds one value, shifts right on insert, left on pop
module sortb_cell
	import sortb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  cell_link_t left,
	input  cell_link_t right,
	output cell_link_t link
);

	value_t val_q;
	logic   occ_q;
	logic   gt;

	// stable insertion: equal values stay ahead of the new one
	assign gt = occ_q && (val_q > ctrl.x);

	assign link.val = val_q;
	assign link.occ = occ_q;
	assign link.gt  = gt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctrl.pop) begin
			occ_q <= right.occ;
		end else if (ctrl.ins) begin
			occ_q <= occ_q | left.occ;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			val_q <= right.val;
		end else if (ctrl.ins) begin
			if (left.gt) begin
				val_q <= left.val;
			end else if (gt || !occ_q) begin
				val_q <= ctrl.x;
			end
		end
	end

endmodule

[design/sort_u32_block_unit.sv]
// top level of the ascending sort block: cell chain, set control and stream ports
// usage
//   input stream (s_*): one unsigned 32-bit value per transfer, tlast marks
//   the final value of a set. output stream (m_*): the set in ascending
//   order, duplicates kept, tlast on the final result, tuser set on every
//   result of a set in which values were discarded for lack of room.
// timing
//   while a set is being collected a value is taken every cycle; each value
//   is compared against all cells at once and slots into the chain in the
//   same cycle. after the tlast transfer the first result shows on the next
//   cycle and the set drains one result per cycle from cell 0 while m_tready
//   is high. s_tready stays low while the set drains; the drain length is
//   set by the chain shifting one cell per transfer.
// capacity
//   MAX_LEN cells; a value arriving with all cells full is discarded.
// reset
//   arst_n empties the chain and clears the drop flag; no sweep is needed.
// stall
//   with m_tready low the chain holds and the current result stays put.
module sort_u32_block_unit
	import sortb_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [VALUE_W-1:0] s_tdata,  // [31:0] value
	input  logic               s_tlast,  // last
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [VALUE_W-1:0] m_tdata,  // [31:0] sorted_value
	output logic               m_tlast,  // final_res
	output logic               m_tuser   // [0] dropped
);

	cell_link_t links [MAX_LEN];
	cell_ctrl_t ctrl;

	logic drain_q;     // set is being emitted
	logic overflow_q;  // sticky drop flag of the set being collected
	logic drop_out_q;  // drop flag shown on the results of the draining set
	logic in_xfer;
	logic out_xfer;
	logic full;

	assign s_tready = !drain_q;
	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = m_tvalid && m_tready;
	assign full     = links[MAX_LEN-1].occ;

	// a value goes in only when there is room; pops happen per output transfer
	assign ctrl.ins = in_xfer && !full;
	assign ctrl.pop = out_xfer;
	assign ctrl.x   = s_tdata;

	// the chain
	for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
		cell_link_t left_l;
		cell_link_t right_l;

		if (i == 0) begin : g_head
			// the head always sees an occupied, not-greater neighbor
			assign left_l = '{val: '0, occ: 1'b1, gt: 1'b0};
		end else begin : g_mid
			assign left_l = links[i-1];
		end

		if (i == MAX_LEN - 1) begin : g_tail
			assign right_l = '{val: '0, occ: 1'b0, gt: 1'b0};
		end else begin : g_body
			assign right_l = links[i+1];
		end

		sortb_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.left   (left_l),
			.right  (right_l),
			.link   (links[i])
		);
	end

	// set control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q    <= 1'b0;
			overflow_q <= 1'b0;
			drop_out_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				if (s_tlast) begin
					// hand the flag to the results and start over
					drain_q    <= 1'b1;
					drop_out_q <= overflow_q | full;
					overflow_q <= 1'b0;
				end else if (full) begin
					overflow_q <= 1'b1;
				end
			end
			if (out_xfer && m_tlast) begin
				drain_q <= 1'b0;
			end
		end
	end

	// results come straight from the head cell
	assign m_tvalid = drain_q;
	assign m_tdata  = links[0].val;
	assign m_tlast  = !links[1].occ;
	assign m_tuser  = drop_out_q;

endmodule

[design/sortb_chk.sv]
// port-level checker for the ascending sort block, bound to the top level
module sortb_chk
	import sortb_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               s_tvalid,
	input logic               s_tready,
	input logic [VALUE_W-1:0] s_tdata,
	input logic               s_tlast,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [VALUE_W-1:0] m_tdata,
	input logic               m_tlast,
	input logic               m_tuser
);

	// input side and output side never run at the same time
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while results pending");

	// a set's last input starts the output
	a_drain_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> m_tvalid)
		else $error("no result after last input");

	// final result ends the output
	a_drain_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
		else $error("results continue past final");

	// drop flag is the same on every result of a set
	a_drop_steady: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> (m_tuser == $past(m_tuser)))
		else $error("drop flag changed within a set");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=>
			(m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)))
		else $error("stalled result changed");

endmodule

bind sort_u32_block_unit sortb_chk u_sortb_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
